@@ sv/kpq_pkg.sv @@
// ----------------------------------------------------------------------------
// kpq_pkg
// Shared types and constants for the keyed priority queue
// ----------------------------------------------------------------------------
package kpq_pkg;

  localparam int KEY_W      = 24;
  localparam int VAL_W      = 32;
  localparam int SIZE_W     = 11;
  localparam int DATA_W     = 72;
  localparam int DEPTH_DEF  = 32;

  localparam logic [KEY_W-1:0]  KEY_LIMIT  = KEY_W'(10000000);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1024);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [VAL_W-1:0]  value;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_UPDATE,
    ACT_POP
  } act_t;

  typedef struct packed {
    logic cmp;
    act_t act;
  } cell_cmd_t;

endpackage

@@ sv/kpq_cell.sv @@
// ----------------------------------------------------------------------------
// kpq_cell
// One slot of the sorted chain: compares against a request key and shifts
// ----------------------------------------------------------------------------
module kpq_cell (
  input  logic              clk,
  input  logic              rst,
  input  kpq_pkg::cell_cmd_t cmd,
  input  logic [kpq_pkg::KEY_W-1:0] cmp_key,
  input  kpq_pkg::entry_t   req,
  input  logic              left_valid,
  input  logic              left_gt,
  input  kpq_pkg::entry_t   left_entry,
  input  logic              right_valid,
  input  kpq_pkg::entry_t   right_entry,
  output logic              valid,
  output logic              gt,
  output logic              eq,
  output kpq_pkg::entry_t   entry
);
  import kpq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      gt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        gt <= valid && (entry.key > cmp_key);
        eq <= valid && (entry.key == cmp_key);
      end
      unique case (cmd.act)
        ACT_HOLD: begin
        end
        ACT_INSERT: begin
          if (!gt) begin
            if (left_gt) begin
              entry <= req;
              valid <= 1'b1;
            end else begin
              entry <= left_entry;
              valid <= left_valid;
            end
          end
        end
        ACT_UPDATE: begin
          if (eq) begin
            entry.value <= req.value;
            entry.size  <= req.size;
          end
        end
        ACT_POP: begin
          entry <= right_entry;
          valid <= right_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/keyed_priority_queue.sv @@
// ----------------------------------------------------------------------------
// keyed_priority_queue
// Priority queue sorted by key, largest at the head, held in a chain of cells
// ----------------------------------------------------------------------------
// an accepted request is registered into ST_EXEC; its result is registered
// when the output is free. No new request is taken until the compare then shift
// pass through the cell chain ends; a stalled result holds the request in ST_EXEC
// reset: rst synchronous, empties the queue and drops any pending result
// ----------------------------------------------------------------------------
module keyed_priority_queue #(
  parameter int QUEUE_DEPTH = kpq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [kpq_pkg::DATA_W-1:0] s_tdata,  // item_key, item_value, item_size
  input  logic                       s_tuser,  // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [kpq_pkg::DATA_W-1:0] m_tdata,  // out_key, out_value, out_size
  output logic                       m_tuser   // success
);
  import kpq_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t    state;
  entry_t    req;
  logic      req_op;
  entry_t    in_entry;
  cell_cmd_t cmd;
  logic      accept, fire, req_ok, match, full, empty;
  logic      res_ok;
  entry_t    res_entry;
  entry_t    out_entry;

  logic [QUEUE_DEPTH-1:0] cell_valid, cell_gt, cell_eq;
  entry_t                 cell_entry [QUEUE_DEPTH];

  assign in_entry = entry_t'(s_tdata[KEY_W+VAL_W+SIZE_W-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign req_ok = (req.key < KEY_LIMIT) && (req.size != '0) && (req.size <= SIZE_LIMIT);
  assign match  = |cell_eq;
  assign full   = cell_valid[QUEUE_DEPTH-1];
  assign empty  = !cell_valid[0];

  always_comb begin
    cmd.cmp   = accept;
    cmd.act   = ACT_HOLD;
    res_ok    = 1'b0;
    res_entry = '0;
    if (fire) begin
      if (req_op == OP_DEQ) begin
        if (!empty) begin
          cmd.act   = ACT_POP;
          res_ok    = 1'b1;
          res_entry = cell_entry[0];
        end
      end else if (req_ok) begin
        if (match) begin
          cmd.act   = ACT_UPDATE;
          res_ok    = 1'b1;
          res_entry = req;
        end else if (!full) begin
          cmd.act   = ACT_INSERT;
          res_ok    = 1'b1;
          res_entry = req;
        end
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic   l_valid, l_gt, r_valid;
    entry_t l_entry, r_entry;
    if (g == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_gt    = 1'b1;
      assign l_entry = req;
    end else begin : g_body
      assign l_valid = cell_valid[g-1];
      assign l_gt    = cell_gt[g-1];
      assign l_entry = cell_entry[g-1];
    end
    if (g == QUEUE_DEPTH-1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = req;
    end else begin : g_mid
      assign r_valid = cell_valid[g+1];
      assign r_entry = cell_entry[g+1];
    end
    kpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .cmp_key     (in_entry.key),
      .req         (req),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .left_entry  (l_entry),
      .right_valid (r_valid),
      .right_entry (r_entry),
      .valid       (cell_valid[g]),
      .gt          (cell_gt[g]),
      .eq          (cell_eq[g]),
      .entry       (cell_entry[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_tvalid  <= 1'b1;
        m_tuser   <= res_ok;
        out_entry <= res_entry;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req    <= in_entry;
            req_op <= s_tuser;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {(DATA_W-KEY_W-VAL_W-SIZE_W)'(0), out_entry};

  // occupied cells form one run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid[QUEUE_DEPTH-1:1] & ~cell_valid[QUEUE_DEPTH-2:0]) == '0)
    else $error("gap in occupied cells");

  // keys are unique so at most one cell matches
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_eq))
    else $error("more than one matching key");

  // a request changes the occupancy by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(cell_valid) <= $countones($past(cell_valid)) + 1) &&
                    ($countones(cell_valid) + 1 >= $countones($past(cell_valid))))
    else $error("occupancy jumped");

  // a result follows each executed request
  a_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("result lost");

endmodule
